[rtl/vfc_pkg.sv]
// Shared types, constants and tables for the voxel face-cull mesher.
package vfc_pkg;

  // Chunk geometry (the side is a power of two, so coordinate splits are shifts)
  localparam int CHUNK_SIDE = 16;
  localparam int CELL_COUNT = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Item field widths
  localparam int IDX_W   = 12;
  localparam int COORD_W = 5;
  localparam int COUNT_W = 18;

  localparam int FACE_COUNT   = 6;
  localparam int CORNER_COUNT = 6;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_MESH  = 1'b1;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  typedef logic [2:0] corner_t;
  localparam corner_t CORNER_FIRST = 3'd0;
  localparam corner_t CORNER_LAST  = 3'd5;

  // Probe sequence: step 0 reads the cell, 1..6 the neighbors, 7 decides
  typedef logic [2:0] step_t;
  localparam step_t STEP_CENTER = 3'd0;
  localparam step_t STEP_DONE   = 3'd7;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_EMIT
  } state_t;

  // Voxel store port request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // One vertex command from the sequencer to the output stage
  typedef struct packed {
    logic               valid;
    logic               clr_cnt;
    face_t              face;
    corner_t            corner;
    logic               last;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
  } emit_cmd_t;

  // Corner offsets, bit 2 = x, bit 1 = y, bit 0 = z
  localparam logic [2:0] CORNER_TBL [FACE_COUNT][CORNER_COUNT] = '{
    '{3'b100, 3'b110, 3'b101, 3'b110, 3'b111, 3'b101},  // +x
    '{3'b000, 3'b001, 3'b010, 3'b010, 3'b001, 3'b011},  // -x
    '{3'b010, 3'b011, 3'b110, 3'b011, 3'b111, 3'b110},  // +y
    '{3'b000, 3'b100, 3'b001, 3'b100, 3'b101, 3'b001},  // -y
    '{3'b001, 3'b101, 3'b111, 3'b001, 3'b111, 3'b011},  // +z
    '{3'b000, 3'b110, 3'b100, 3'b000, 3'b010, 3'b110}   // -z
  };

  function automatic logic [2:0] corner_ofs(face_t f, corner_t c);
    return CORNER_TBL[f][c];
  endfunction

  // Linear-index distance to the neighbor across a face
  function automatic logic [ADDR_W-1:0] nb_stride(face_t f);
    logic [ADDR_W-1:0] s;
    unique case (f)
      FACE_PX, FACE_NX: s = ADDR_W'(1);
      FACE_PY, FACE_NY: s = ADDR_W'(CHUNK_SIDE);
      default:          s = ADDR_W'(CHUNK_SIDE * CHUNK_SIDE);
    endcase
    return s;
  endfunction

endpackage

[rtl/vfc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vfc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/vfc_ctrl.sv]
// Sequencer: store clear, voxel writes, neighbor probing and face walk.
module vfc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       kind,
  input  logic [vfc_pkg::IDX_W-1:0]  cell_index,
  input  logic                       solid,
  output logic                       busy,
  output vfc_pkg::ram_req_t          ram_req,
  input  logic                       ram_rdata,
  output vfc_pkg::emit_cmd_t         cmd
);
  import vfc_pkg::*;

  state_t state, state_next;

  // Control registers
  logic [ADDR_W-1:0] clr_addr;
  step_t             step;

  // Per-item payload registers
  logic [ADDR_W-1:0]     base;
  logic                  in_rng;
  logic [FACE_COUNT-1:0] bnd;
  logic [COORD_W-1:0]    cx, cy, cz;
  logic                  center_q;
  logic [FACE_COUNT-1:0] exp_q;
  face_t                 face_q;
  corner_t               corner_q;

  // Item decode at accept
  logic                  accept;
  logic [31:0]           idx_w, x_w, y_w, z_w;
  logic                  in_rng_now;
  logic [FACE_COUNT-1:0] bnd_now;

  // Probe path
  face_t                 probe_face;
  logic [ADDR_W-1:0]     stride;
  logic [ADDR_W-1:0]     nb_addr;
  logic [ADDR_W-1:0]     probe_addr;
  logic [FACE_COUNT-1:0] exp_all;
  logic                  mesh_go;

  // Face walk
  logic [FACE_COUNT-1:0] later;
  logic                  any_later;
  face_t                 next_face;
  logic                  emit_last;

  function automatic face_t first_face(logic [FACE_COUNT-1:0] m);
    face_t r;
    r = FACE_PX;
    for (int i = FACE_COUNT - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = face_t'(3'(i));
      end
    end
    return r;
  endfunction

  // Split the linear index into coordinates and boundary flags
  always_comb begin
    accept     = start && (state == ST_IDLE);
    idx_w      = 32'(cell_index);
    x_w        = idx_w % CHUNK_SIDE;
    y_w        = (idx_w / CHUNK_SIDE) % CHUNK_SIDE;
    z_w        = idx_w / (CHUNK_SIDE * CHUNK_SIDE);
    in_rng_now = idx_w < CELL_COUNT;
    bnd_now[FACE_PX] = x_w == CHUNK_SIDE - 1;
    bnd_now[FACE_NX] = x_w == 0;
    bnd_now[FACE_PY] = y_w == CHUNK_SIDE - 1;
    bnd_now[FACE_NY] = y_w == 0;
    bnd_now[FACE_PZ] = z_w >= CHUNK_SIDE - 1;
    bnd_now[FACE_NZ] = z_w == 0;
  end

  // Shared address adder: base plus or minus the face stride
  always_comb begin
    probe_face = face_t'(step - 3'd1);
    stride     = nb_stride(probe_face);
    nb_addr    = probe_face[0] ? (base - stride) : (base + stride);
    if (step == STEP_CENTER || step == STEP_DONE) begin
      probe_addr = base;
    end else if (bnd[probe_face]) begin
      probe_addr = base;
    end else begin
      probe_addr = nb_addr;
    end
  end

  // Exposure once the last neighbor read returns
  always_comb begin
    exp_all          = exp_q;
    exp_all[FACE_NZ] = bnd[FACE_NZ] | ~ram_rdata;
    mesh_go          = in_rng && center_q && (|exp_all);
  end

  // Next exposed face after the current one
  always_comb begin
    later     = exp_q & FACE_COUNT'(6'h3F << (3'(face_q) + 3'd1));
    any_later = |later;
    next_face = first_face(later);
    emit_last = (corner_q == CORNER_LAST) && !any_later;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && kind == KIND_MESH) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (step == STEP_DONE) begin
          state_next = mesh_go ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy          = state != ST_IDLE;
    ram_req.we    = 1'b0;
    ram_req.waddr = clr_addr;
    ram_req.wdata = 1'b0;
    ram_req.raddr = probe_addr;
    cmd.valid     = 1'b0;
    cmd.clr_cnt   = 1'b0;
    cmd.face      = face_q;
    cmd.corner    = corner_q;
    cmd.last      = emit_last;
    cmd.cx        = cx;
    cmd.cy        = cy;
    cmd.cz        = cz;
    unique case (state)
      ST_CLEAR: begin
        ram_req.we = 1'b1;
      end
      ST_IDLE: begin
        if (start && kind == KIND_WRITE) begin
          ram_req.we    = in_rng_now;
          ram_req.waddr = ADDR_W'(cell_index);
          ram_req.wdata = solid;
          cmd.clr_cnt   = 1'b1;
        end
      end
      ST_PROBE: begin
      end
      ST_EMIT: begin
        cmd.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      step     <= STEP_CENTER;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (accept) begin
        step <= STEP_CENTER;
      end else if (state == ST_PROBE) begin
        step <= step + 3'd1;
      end
    end
  end

  // Item payload, probe results and face walk
  always_ff @(posedge clk) begin
    if (accept) begin
      base   <= ADDR_W'(cell_index);
      in_rng <= in_rng_now;
      bnd    <= bnd_now;
      cx     <= COORD_W'(x_w);
      cy     <= COORD_W'(y_w);
      cz     <= COORD_W'(z_w);
    end
    if (state == ST_PROBE) begin
      // read data returned here belongs to the previous step
      if (step == 3'd1) begin
        center_q <= ram_rdata;
      end
      for (int i = 0; i < FACE_COUNT - 1; i++) begin
        if (step == 3'(i + 2)) begin
          exp_q[i] <= bnd[i] | ~ram_rdata;
        end
      end
      if (step == STEP_DONE) begin
        exp_q    <= exp_all;
        face_q   <= first_face(exp_all);
        corner_q <= CORNER_FIRST;
      end
    end
    if (state == ST_EMIT) begin
      if (corner_q == CORNER_LAST) begin
        corner_q <= CORNER_FIRST;
        face_q   <= next_face;
      end else begin
        corner_q <= corner_q + 3'd1;
      end
    end
  end

endmodule

[rtl/vfc_emit.sv]
// Output stage: vertex coordinates, running vertex count and result strobe.
module vfc_emit (
  input  logic                         clk,
  input  logic                         rst,
  input  vfc_pkg::emit_cmd_t           cmd,
  output logic                         strobe,
  output logic [vfc_pkg::COORD_W-1:0]  vertex_x,
  output logic [vfc_pkg::COORD_W-1:0]  vertex_y,
  output logic [vfc_pkg::COORD_W-1:0]  vertex_z,
  output logic [2:0]                   face,
  output logic [vfc_pkg::COUNT_W-1:0]  vertex_number,
  output logic                         last
);
  import vfc_pkg::*;

  logic [COUNT_W-1:0] vertex_counter;
  logic [2:0]         ofs;

  assign ofs = corner_ofs(cmd.face, cmd.corner);

  // Counter and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_counter <= '0;
      strobe         <= 1'b0;
    end else begin
      strobe <= cmd.valid;
      if (cmd.clr_cnt) begin
        vertex_counter <= '0;
      end else if (cmd.valid) begin
        vertex_counter <= vertex_counter + COUNT_W'(1);
      end
    end
  end

  // Vertex payload, coordinates wrap at the field width
  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      vertex_x      <= cmd.cx + COORD_W'(ofs[2]);
      vertex_y      <= cmd.cy + COORD_W'(ofs[1]);
      vertex_z      <= cmd.cz + COORD_W'(ofs[0]);
      face          <= 3'(cmd.face);
      vertex_number <= vertex_counter;
      last          <= cmd.last;
    end
  end

endmodule

[rtl/voxel_face_cull_mesher.sv]
// Voxel face-cull mesher: top level tying sequencer, voxel store and output stage.
//
// Usage:
//   Items enter on start/kind/cell_index/solid and are taken at a clock edge
//   with start high and busy low. A write item (kind 0) stores one voxel bit
//   and clears the vertex count; busy stays low.
//   A mesh item (kind 1) reads the cell and its six neighbors from the voxel
//   store, one read a cycle through a single read port and one shared address
//   adder, then walks the exposed faces and emits six vertices per face.
//   Busy stays high through the probe steps and while the vertices are
//   emitted. The first vertex reaches the ports through the output stage
//   register once probing ends, then one vertex every cycle; last marks the
//   final one. Results are shown for one cycle with strobe high; the receiver
//   has no way to hold them, and the final vertex may still be on the ports
//   while the next item is taken.
//   After reset, busy stays high while the store is swept to empty, one
//   voxel per cycle; the vertex count resets to zero.
module voxel_face_cull_mesher (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [vfc_pkg::IDX_W-1:0]    cell_index,
  input  logic                         solid,
  output logic                         strobe,
  output logic [vfc_pkg::COORD_W-1:0]  vertex_x,
  output logic [vfc_pkg::COORD_W-1:0]  vertex_y,
  output logic [vfc_pkg::COORD_W-1:0]  vertex_z,
  output logic [2:0]                   face,
  output logic [vfc_pkg::COUNT_W-1:0]  vertex_number,
  output logic                         last
);
  import vfc_pkg::*;

  ram_req_t  ram_req;
  logic      ram_rdata;
  emit_cmd_t cmd;

  // Sequencer
  vfc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .kind       (kind),
    .cell_index (cell_index),
    .solid      (solid),
    .busy       (busy),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .cmd        (cmd)
  );

  // Voxel store
  vfc_ram #(
    .WIDTH (1),
    .DEPTH (CELL_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Output stage
  vfc_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .strobe        (strobe),
    .vertex_x      (vertex_x),
    .vertex_y      (vertex_y),
    .vertex_z      (vertex_z),
    .face          (face),
    .vertex_number (vertex_number),
    .last          (last)
  );

endmodule

[rtl/vfc_checker.sv]
// Port-level checks for the voxel face-cull mesher, bound to the top level.
module vfc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         kind,
  input logic                         strobe,
  input logic [vfc_pkg::COUNT_W-1:0]  vertex_number,
  input logic                         last
);
  import vfc_pkg::*;

  // A mesh item that is taken makes the block busy
  a_mesh_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_MESH |=> busy)
    else $error("mesh item taken but block not busy");

  // Vertices of one cell come back to back
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a vertex burst");

  // A burst ends before the next item can produce vertices
  a_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("vertex right after the final vertex of a cell");

  // Vertex numbers count up by one inside a burst
  a_count: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> vertex_number == COUNT_W'($past(vertex_number) + COUNT_W'(1)))
    else $error("vertex number did not advance by one");

  // The item is still in progress while its vertices are pending
  a_busy_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("block idle in the middle of a burst");

endmodule

bind voxel_face_cull_mesher vfc_checker u_vfc_checker (.*);
